>>> hw/rtl/slot_free_stack_allocator_unit_defines.svh
// Assertion macros used by the allocator controller RTL.
`ifndef SLOT_FREE_STACK_ALLOCATOR_UNIT_DEFINES_SVH
`define SLOT_FREE_STACK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define SFSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define SFSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sfsa_pkg.sv
`timescale 1ns / 1ps
package sfsa_pkg;

  localparam int ENTRIES_DEF  = 512;
  localparam int RESERVED_DEF = 32;
  localparam int SLOT_W       = 10;
  localparam int COUNT_W      = 32;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_SWAP,
    ST_DONE
  } sfsa_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] change_count;
    logic [SLOT_W-1:0]  free_left;
    logic               accepted;
    logic [SLOT_W-1:0]  slot_out;
  } sfsa_result_t;

endpackage

>>> hw/rtl/slot_free_stack_allocator_unit.sv
`timescale 1ns / 1ps
// Slot allocator that keeps free slot numbers on a stack held in one synchronous RAM with
// a registered read. Each input beat yields exactly one result beat. An allocate of a named
// slot scans the stack one entry per cycle through the RAM read port, and the reset action
// rewrites the stack one entry per cycle. After rst the same fill pass runs before s_tready
// rises. A finished result waits in the output register while the next beat is taken.
module slot_free_stack_allocator_unit
  import sfsa_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int RESERVED = RESERVED_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // action[1:0], slot_index[11:2], zero[15:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // slot_out[9:0], accepted[10], free_left[20:11],
                                 // change_count[52:21], zero[55:53]
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic             out_ready;
  logic             out_push;
  sfsa_result_t     result;
  sfsa_result_t     out_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_rdata;

  assign out_ready = !m_tvalid || m_tready;

  sfsa_ctrl #(
    .ENTRIES  (ENTRIES),
    .RESERVED (RESERVED),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tdata[1:0]),
    .in_slot   (s_tdata[11:2]),
    .out_ready (out_ready),
    .out_push  (out_push),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sfsa_stack_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .DATA_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_data <= result;
    end
  end

  assign m_tdata = {3'b000, out_data};

endmodule

>>> hw/rtl/sfsa_stack_mem.sv
`timescale 1ns / 1ps
module sfsa_stack_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/sfsa_ctrl.sv
`timescale 1ns / 1ps
`include "slot_free_stack_allocator_unit_defines.svh"
module sfsa_ctrl
  import sfsa_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int RESERVED = RESERVED_DEF,
  parameter int IDX_W    = $clog2(ENTRIES),
  parameter int CNT_W    = $clog2(ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic               out_ready,
  output logic               out_push,
  output sfsa_result_t       result,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output logic [IDX_W-1:0]   mem_wdata,
  output logic               mem_re,
  output logic [IDX_W-1:0]   mem_raddr,
  input  logic [IDX_W-1:0]   mem_rdata
);

  localparam int FILL = (ENTRIES > RESERVED) ? ENTRIES - RESERVED : 0;
  localparam logic [CNT_W-1:0] FILL_C = CNT_W'(FILL);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);
  localparam logic [SLOT_W-1:0] NONE = SLOT_W'(ENTRIES);
  localparam sfsa_state_t FILL_ST = (FILL == 0) ? ST_IDLE : ST_FILL;

  sfsa_state_t state, state_next;
  logic [CNT_W-1:0] depth, depth_next;
  logic [COUNT_W-1:0] counter, counter_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [SLOT_W-1:0] req_slot, req_slot_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic res_ok, res_ok_next;
  logic fill_ack, fill_ack_next;

  logic [CNT_W-1:0] depth_m1;
  logic [CNT_W-1:0] idx_p1;
  logic [31:0] in_slot_w;
  logic [31:0] req_slot_w;
  logic [31:0] rdata_w;
  logic [31:0] depth_w;
  logic [IDX_W-1:0] fill_val;
  logic is_reserved;
  logic is_any;

  assign depth_m1    = depth - 1'b1;
  assign idx_p1      = CNT_W'(idx) + 1'b1;
  assign in_slot_w   = 32'(in_slot);
  assign req_slot_w  = 32'(req_slot);
  assign rdata_w     = 32'(mem_rdata);
  assign depth_w     = 32'(depth);
  assign fill_val    = IDX_W'(RESERVED) + idx;
  assign is_reserved = in_slot_w < 32'(RESERVED);
  assign is_any      = in_slot_w >= 32'(ENTRIES);

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FILL_ST;
      depth    <= FILL_C;
      counter  <= '0;
      idx      <= '0;
      fill_ack <= 1'b0;
    end else begin
      state    <= state_next;
      depth    <= depth_next;
      counter  <= counter_next;
      idx      <= idx_next;
      fill_ack <= fill_ack_next;
    end
  end

  always_ff @(posedge clk) begin
    req_slot <= req_slot_next;
    res_slot <= res_slot_next;
    res_ok   <= res_ok_next;
  end

  always_comb begin
    state_next    = state;
    depth_next    = depth;
    counter_next  = counter;
    idx_next      = idx;
    req_slot_next = req_slot;
    res_slot_next = res_slot;
    res_ok_next   = res_ok;
    fill_ack_next = fill_ack;
    mem_we        = 1'b0;
    mem_waddr     = idx;
    mem_wdata     = fill_val;
    mem_re        = 1'b0;
    mem_raddr     = depth_m1[IDX_W-1:0];
    out_push      = 1'b0;

    unique case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = fill_val;
        idx_next  = idx + 1'b1;
        if (idx_p1 == FILL_C) begin
          idx_next   = '0;
          state_next = fill_ack ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_slot_next = in_slot;
          res_slot_next = NONE;
          res_ok_next   = 1'b0;
          state_next    = ST_DONE;
          case (in_action)
            ACT_ALLOC: begin
              if (is_reserved) begin
                res_slot_next = in_slot;
                res_ok_next   = 1'b1;
              end else if (is_any) begin
                if (depth != '0) begin
                  mem_re     = 1'b1;
                  mem_raddr  = depth_m1[IDX_W-1:0];
                  state_next = ST_POP;
                end
              end else if (depth == '0) begin
                res_slot_next = in_slot;
                res_ok_next   = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = ST_SCAN;
              end
            end
            ACT_FREE: begin
              if (!is_any && depth < ENTRIES_C) begin
                res_ok_next = 1'b1;
                if (!is_reserved) begin
                  mem_we       = 1'b1;
                  mem_waddr    = depth[IDX_W-1:0];
                  mem_wdata    = in_slot_w[IDX_W-1:0];
                  depth_next   = depth + 1'b1;
                  counter_next = counter + 1'b1;
                end
              end
            end
            ACT_RESET: begin
              idx_next      = '0;
              depth_next    = FILL_C;
              fill_ack_next = 1'b1;
              state_next    = (FILL == 0) ? ST_DONE : ST_FILL;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_POP: begin
        res_slot_next = rdata_w[SLOT_W-1:0];
        res_ok_next   = 1'b1;
        depth_next    = depth_m1;
        counter_next  = counter + 1'b1;
        state_next    = ST_DONE;
      end

      ST_SCAN: begin
        if (rdata_w == req_slot_w) begin
          mem_re     = 1'b1;
          mem_raddr  = depth_m1[IDX_W-1:0];
          state_next = ST_SWAP;
        end else if (idx_p1 == depth) begin
          res_slot_next = req_slot;
          res_ok_next   = 1'b1;
          state_next    = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[IDX_W-1:0];
          idx_next  = idx + 1'b1;
        end
      end

      ST_SWAP: begin
        mem_we        = 1'b1;
        mem_waddr     = idx;
        mem_wdata     = mem_rdata;
        depth_next    = depth_m1;
        counter_next  = counter + 1'b1;
        res_slot_next = req_slot;
        res_ok_next   = 1'b1;
        state_next    = ST_DONE;
      end

      ST_DONE: begin
        fill_ack_next = 1'b0;
        if (out_ready) begin
          out_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign result.slot_out     = res_slot;
  assign result.accepted     = res_ok;
  assign result.free_left    = depth_w[SLOT_W-1:0];
  assign result.change_count = counter;

  `SFSA_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
  `SFSA_ASSERT_IMP(a_depth_bound, 1'b1, depth <= ENTRIES_C, "stack depth beyond capacity")
  `SFSA_ASSERT_IMP(a_pop_nonempty, state == ST_POP, depth != '0, "pop from an empty stack")
  `SFSA_ASSERT_IMP(a_cnt_step, !$past(rst), (counter == $past(counter)) || (counter == $past(counter) + 32'd1), "change counter jumped")
  `SFSA_ASSERT_NXT(a_push_idle, out_push, state == ST_IDLE, "no return to idle after result")

endmodule

>>> tb/tb_slot_free_stack_allocator_unit.sv
`timescale 1ns / 1ps
module tb_slot_free_stack_allocator_unit;
  import sfsa_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int RESERVED = RESERVED_DEF;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int MAX_GAP = 17;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {MIXED_TRAFFIC, DRAIN_STACK, FILL_STACK} traffic_t;

  class free_stack_mirror;
    logic [SLOT_W-1:0] stack_mem [ENTRIES];
    int unsigned depth;
    logic [COUNT_W-1:0] changes;
    sfsa_result_t grants_due [$];
    int unsigned errors;

    function void refill();
      int s;
      for (s = RESERVED; s < ENTRIES; s++) stack_mem[IDX_W'(s - RESERVED)] = SLOT_W'(s);
      depth = (RESERVED < ENTRIES) ? ENTRIES - RESERVED : 0;
    endfunction

    function void clear();
      int i;
      for (i = 0; i < ENTRIES; i++) stack_mem[IDX_W'(i)] = '0;
      refill();
      changes = '0;
      errors = 0;
      grants_due.delete();
    endfunction

    function void take_request(logic [1:0] act, logic [SLOT_W-1:0] slot);
      sfsa_result_t r;
      int unsigned i;
      int unsigned slot_w;
      logic [SLOT_W-1:0] t;
      bit found;
      r.slot_out = SLOT_W'(ENTRIES);
      r.accepted = 1'b0;
      found = 1'b0;
      slot_w = 32'(slot);
      case (act)
        ACT_ALLOC: begin
          if (slot_w < RESERVED) begin
            r.slot_out = slot;
            r.accepted = 1'b1;
          end else if (slot_w >= ENTRIES) begin
            if (depth != 0) begin
              depth--;
              changes++;
              r.slot_out = stack_mem[IDX_W'(depth)];
              r.accepted = 1'b1;
            end
          end else begin
            r.slot_out = slot;
            r.accepted = 1'b1;
            for (i = 0; i < depth; i++) begin
              if (!found && stack_mem[IDX_W'(i)] == slot) begin
                found = 1'b1;
                depth--;
                changes++;
                t = stack_mem[IDX_W'(i)];
                stack_mem[IDX_W'(i)] = stack_mem[IDX_W'(depth)];
                stack_mem[IDX_W'(depth)] = t;
              end
            end
          end
        end
        ACT_FREE: begin
          if (slot_w < ENTRIES && depth < ENTRIES) begin
            r.accepted = 1'b1;
            if (slot_w >= RESERVED) begin
              stack_mem[IDX_W'(depth)] = slot;
              depth++;
              changes++;
            end
          end
        end
        ACT_RESET: refill();
        default: ;
      endcase
      r.free_left = SLOT_W'(depth);
      r.change_count = changes;
      grants_due.push_back(r);
    endfunction

    function void check_grant(logic [$bits(sfsa_result_t)-1:0] bits);
      sfsa_result_t got;
      sfsa_result_t want;
      got = sfsa_result_t'(bits);
      if (grants_due.size() == 0) begin
        $error("result beat with no request pending: %h", bits);
        errors++;
      end else begin
        want = grants_due.pop_front();
        if (got.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
          errors++;
        end
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
          errors++;
        end
        if (got.free_left !== want.free_left) begin
          $error("free_left: expected %0d, actual %0d", want.free_left, got.free_left);
          errors++;
        end
        if (got.change_count !== want.change_count) begin
          $error("change_count: expected %0d, actual %0d", want.change_count,
                 got.change_count);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [55:0] m_tdata;

  free_stack_mirror mirror;
  bit tx_gapless;
  bit rx_gapless;
  int unsigned results_seen;
  int unsigned idle_run;

  slot_free_stack_allocator_unit #(
    .ENTRIES(ENTRIES),
    .RESERVED(RESERVED)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(logic [1:0] act, logic [SLOT_W-1:0] slot);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, slot, act};
    do @(posedge clk); while (s_tready !== 1'b1);
    mirror.take_request(act, slot);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.grants_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return SLOT_W'($urandom_range(0, RESERVED - 1));
    if (r < 7) return SLOT_W'($urandom_range(RESERVED, ENTRIES - 1));
    if (r == 7) return SLOT_W'($urandom_range(ENTRIES, 1023));
    if (r == 8) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return SLOT_W'(RESERVED - 1);
        2: return SLOT_W'(RESERVED);
        default: return SLOT_W'(ENTRIES - 1);
      endcase
    end
    case ($urandom_range(0, 2))
      0: return SLOT_W'(ENTRIES);
      1: return 10'h3ff;
      default: return SLOT_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic run_traffic(traffic_t kind, int count);
    int n;
    int r;
    logic [1:0] act;
    logic [SLOT_W-1:0] slot;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      act = ACT_NONE;
      slot = SLOT_W'($urandom_range(0, 1023));
      case (kind)
        MIXED_TRAFFIC: begin
          if (r < 25) begin
            act = ACT_ALLOC;
            slot = SLOT_W'($urandom_range(ENTRIES, 1023));
          end else if (r < 45) begin
            act = ACT_ALLOC;
            slot = pick_slot();
          end else if (r < 90) begin
            act = ACT_FREE;
            slot = pick_slot();
          end else if (r < 95) begin
            act = ACT_RESET;
          end
        end
        DRAIN_STACK: begin
          if (r < 95) begin
            act = ACT_ALLOC;
            slot = SLOT_W'($urandom_range(ENTRIES, 1023));
          end else if (r < 97) begin
            act = ACT_ALLOC;
            slot = pick_slot();
          end else if (r < 99) begin
            act = ACT_FREE;
            slot = pick_slot();
          end
        end
        default: begin
          if (r < 93) begin
            act = ACT_FREE;
            slot = SLOT_W'($urandom_range(RESERVED, ENTRIES - 1));
          end else if (r < 96) begin
            act = ACT_FREE;
            slot = pick_slot();
          end else if (r < 99) begin
            act = ACT_ALLOC;
            slot = pick_slot();
          end
        end
      endcase
      send_beat(act, slot);
    end
  endtask

  initial begin
    int gap;
    bit held;
    held = 1'b0;
    results_seen = 0;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = rx_gapless ? 0 : $urandom_range(0, MAX_GAP);
      if (!held && results_seen == HOLD_AT) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      mirror.check_grant(m_tdata[$bits(sfsa_result_t)-1:0]);
      results_seen++;
    end
  end

  initial begin
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    mirror = new;
    mirror.clear();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_beat(ACT_ALLOC, SLOT_W'(ENTRIES));
    send_beat(ACT_ALLOC, 10'h3ff);
    send_beat(ACT_ALLOC, 10'd0);
    send_beat(ACT_ALLOC, SLOT_W'(RESERVED - 1));
    send_beat(ACT_ALLOC, SLOT_W'(RESERVED));
    send_beat(ACT_ALLOC, SLOT_W'(RESERVED));
    send_beat(ACT_ALLOC, SLOT_W'(ENTRIES - 1));
    send_beat(ACT_ALLOC, 10'd300);
    send_beat(ACT_FREE, SLOT_W'(ENTRIES - 1));
    send_beat(ACT_FREE, SLOT_W'(ENTRIES - 1));
    send_beat(ACT_FREE, 10'd0);
    send_beat(ACT_FREE, SLOT_W'(ENTRIES));
    send_beat(ACT_FREE, 10'h3ff);
    send_beat(ACT_NONE, 10'd0);
    send_beat(ACT_NONE, 10'h3ff);
    send_beat(ACT_RESET, 10'd0);
    send_beat(ACT_ALLOC, SLOT_W'(RESERVED));
    send_beat(ACT_FREE, SLOT_W'(RESERVED));
    send_beat(ACT_ALLOC, 10'd700);
    send_beat(ACT_ALLOC, SLOT_W'(ENTRIES - 1));
    send_beat(ACT_FREE, SLOT_W'(RESERVED - 1));
    send_beat(ACT_ALLOC, 10'h2aa);
    send_beat(ACT_FREE, 10'h155);
    settle();

    run_traffic(MIXED_TRAFFIC, 250);
    settle();

    tx_gapless = 1'b1;
    rx_gapless = 1'b1;
    send_beat(ACT_RESET, SLOT_W'($urandom_range(0, 1023)));
    run_traffic(DRAIN_STACK, 540);
    settle();

    tx_gapless = 1'b0;
    run_traffic(FILL_STACK, 600);
    settle();

    rx_gapless = 1'b0;
    run_traffic(MIXED_TRAFFIC, 150);
    s_tvalid <= 1'b0;
    while (mirror.grants_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mirror.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sfsa_pkg.sv
hw/rtl/sfsa_stack_mem.sv
hw/rtl/sfsa_ctrl.sv
hw/rtl/slot_free_stack_allocator_unit.sv
tb/tb_slot_free_stack_allocator_unit.sv
